/* rtl/core/vsc_pkg.sv */
// ----------------------------------------------------------------------------
// vsc_pkg
// Types, codes and constants shared by the sensor conditioner.
// ----------------------------------------------------------------------------
package vsc_pkg;

    localparam int DEF_MAX_POINTS = 16;

    // operation codes
    localparam logic [1:0] OP_CONTROL = 2'd0;
    localparam logic [1:0] OP_CALIB   = 2'd1;
    localparam logic [1:0] OP_POINT   = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_ZERO_P   = 3'd0;
    localparam logic [2:0] REG_ZERO_I   = 3'd1;
    localparam logic [2:0] REG_ZERO_E   = 3'd2;
    localparam logic [2:0] REG_GAIN     = 3'd3;
    localparam logic [2:0] REG_KEEP     = 3'd4;
    localparam logic [2:0] REG_NEW      = 3'd5;
    localparam logic [2:0] REG_PMAX     = 3'd6;
    localparam logic [2:0] REG_NPOINTS  = 3'd7;

    // oxygen quadratic coefficients in Q.24
    localparam logic [10:0] O2_C2 = 11'd1678;
    localparam logic [20:0] O2_C1 = 21'd1088841;
    localparam logic [28:0] O2_C0 = 29'd494508442;

    // ceil(2^33 / 100): exact floor division by 100 for products below 2^30
    localparam logic [26:0] GAIN_RECIP = 27'd85899346;
    localparam int          DIV_BITS   = 26;

    // smoothing slots
    localparam logic [2:0] SM_PRESS = 3'd0;
    localparam logic [2:0] SM_INSP  = 3'd1;
    localparam logic [2:0] SM_EXP   = 3'd2;
    localparam logic [2:0] SM_OXY   = 3'd3;
    localparam logic [2:0] SM_CALP  = 3'd4;
    localparam logic [2:0] SM_CALI  = 3'd5;
    localparam logic [2:0] SM_CALE  = 3'd6;

    typedef struct packed {
        logic [1:0]  op;
        logic [9:0]  raw_pressure;
        logic [9:0]  raw_insp_flow;
        logic [9:0]  raw_exp_flow;
        logic [9:0]  raw_oxygen;
        logic [3:0]  point_index;
        logic [9:0]  point_insp_x;
        logic [9:0]  point_exp_x;
        logic [15:0] point_flow_y;
    } t_in;

    typedef struct packed {
        logic [15:0] inst_pressure;
        logic [15:0] mean_pressure;
        logic [15:0] mean_insp_flow;
        logic [15:0] mean_exp_flow;
        logic [7:0]  mean_oxygen;
        logic        pressure_alarm;
        logic [9:0]  cal_pressure_raw;
        logic [9:0]  cal_insp_raw;
        logic [9:0]  cal_exp_raw;
    } t_out;

    typedef struct packed {
        logic [9:0]  insp_x;
        logic [9:0]  exp_x;
        logic [15:0] flow_y;
    } t_point;

    typedef enum logic [4:0] {
        S_IDLE,
        S_PMUL,
        S_PFIN,
        S_DIV,
        S_FSTART,
        S_FRD,
        S_FLOAD,
        S_FRD2,
        S_FCHK,
        S_FMUL,
        S_FFIN,
        S_FDONE,
        S_OXY1,
        S_OXY2,
        S_SMA,
        S_SMB,
        S_OUT
    } t_state;

endpackage

/* rtl/core/ventilator_sensor_conditioner.sv */
// ----------------------------------------------------------------------------
// ventilator_sensor_conditioner
// Pressure scaling, table-based flow linearisation, oxygen quadratic and
// exponential smoothing of one set of sensor samples per word.
// ----------------------------------------------------------------------------
// One word is handled at a time. A control or calibration word passes through
// pressure scaling by a multiply and a reciprocal multiply, per flow a
// breakpoint scan through the table memory segment by segment and, for an
// interpolated value, one pass of the bit-serial divider, then, for a control
// word, the oxygen quadratic, and each smoothed value through the shared
// multiply stage, before its result is offered. The result is held in the
// output register until taken; no new word is accepted meanwhile.
module ventilator_sensor_conditioner
    import vsc_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);

    localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW0 = $clog2(MAX_POINTS + 1);
    localparam int NW  = (CW0 > 5) ? CW0 : 5;
    localparam logic [NW-1:0] NMAX = NW'(MAX_POINTS);

    // configuration
    logic [9:0]  r_zero_p, r_zero_i, r_zero_e;
    logic [15:0] r_gain, r_pmax;
    logic [16:0] r_keep, r_new;
    logic [4:0]  r_npoints;

    // table memory
    t_point      mem [MAX_POINTS];
    t_point      r_rdata;
    logic [AW-1:0] rd_addr;

    t_state      r_state, n_state;
    t_in         r_in;

    logic [15:0] r_sp, r_si, r_se, r_so;
    logic [9:0]  r_cp, r_ci, r_ce;
    logic        r_alarm;
    logic [15:0] r_inst, r_fi, r_fe, r_oxq;

    // divider
    logic [DIV_BITS-1:0] r_num, r_quo;
    logic [9:0]  r_den, r_rem;
    logic [4:0]  r_cnt;
    logic [10:0] rem_sh;
    logic        div_ge;
    logic [52:0] p_scaled;

    // flow scan
    logic        r_ch;
    logic [NW-1:0] r_idx;
    t_point      r_prev, r_cur;
    logic [9:0]  r_p;
    logic [15:0] r_flow;
    logic [NW-1:0] n_eff;

    // oxygen
    logic [19:0] r_tt;
    logic [30:0] r_c1t;

    // smoothing
    logic [2:0]  r_k;
    logic [32:0] r_acc;
    logic [15:0] sm_prev, sm_x;
    logic [33:0] sm_sum;
    logic [17:0] sm_res;

    logic        in_fire;
    logic        in_op_ok;
    logic [9:0]  zero_sel, raw_sel;
    logic [9:0]  x_prev, x_cur;
    logic        seg_hit;
    logic [9:0]  span, dx;
    logic [32:0] oxy_v;
    logic [2:0]  k_next;
    logic        k_last;

    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_in_valid && o_in_ready;
    assign in_op_ok    = (i_in.op == OP_CONTROL) || (i_in.op == OP_CALIB);

    assign n_eff = (NW'(r_npoints) > NMAX) ? NMAX : NW'(r_npoints);

    assign zero_sel = r_ch ? r_zero_e : r_zero_i;
    assign raw_sel  = r_ch ? r_in.raw_exp_flow : r_in.raw_insp_flow;
    assign x_prev   = r_ch ? r_prev.exp_x : r_prev.insp_x;
    assign x_cur    = r_ch ? r_rdata.exp_x : r_rdata.insp_x;
    assign seg_hit  = (x_prev <= r_p) && (r_p <= x_cur);
    assign span     = (r_ch ? r_cur.exp_x : r_cur.insp_x) - x_prev;
    assign dx       = r_p - x_prev;

    assign rem_sh = {r_rem, r_num[DIV_BITS-1]};
    assign div_ge = rem_sh >= {1'b0, r_den};

    // quotient by 100 sits in bits 52:33
    assign p_scaled = r_num * GAIN_RECIP;

    assign oxy_v = 33'(O2_C2 * r_tt) + 33'(O2_C0) - 33'(r_c1t);

    // smoothing operand select
    always_comb begin
        case (r_k)
            SM_PRESS: begin sm_prev = r_sp; sm_x = r_inst; end
            SM_INSP:  begin sm_prev = r_si; sm_x = r_fi; end
            SM_EXP:   begin sm_prev = r_se; sm_x = r_fe; end
            SM_OXY:   begin sm_prev = r_so; sm_x = r_oxq; end
            SM_CALP:  begin sm_prev = {6'd0, r_cp}; sm_x = {6'd0, r_in.raw_pressure}; end
            SM_CALI:  begin sm_prev = {6'd0, r_ci}; sm_x = {6'd0, r_in.raw_insp_flow}; end
            SM_CALE:  begin sm_prev = {6'd0, r_ce}; sm_x = {6'd0, r_in.raw_exp_flow}; end
            default:  begin sm_prev = 16'd0; sm_x = 16'd0; end
        endcase
    end

    assign sm_sum = 34'(r_acc) + 34'(sm_x * r_new);
    assign sm_res = sm_sum[33:16];

    // control words skip the calibration slots, calibration words skip oxygen
    always_comb begin
        if (r_in.op == OP_CONTROL) begin
            k_next = r_k + 3'd1;
            k_last = (r_k == SM_OXY);
        end else begin
            k_next = (r_k == SM_EXP) ? SM_CALP : r_k + 3'd1;
            k_last = (r_k == SM_CALE);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (in_fire && in_op_ok) n_state = S_PMUL;
            S_PMUL:   n_state = (r_in.raw_pressure < r_zero_p) ? S_FSTART : S_PFIN;
            S_DIV:    if (r_cnt == 5'(DIV_BITS - 1)) n_state = S_FFIN;
            S_PFIN:   n_state = S_FSTART;
            S_FSTART: n_state = ((raw_sel < zero_sel) || (n_eff < NW'(2))) ? S_FDONE : S_FRD;
            S_FRD:    n_state = S_FLOAD;
            S_FLOAD:  n_state = S_FRD2;
            S_FRD2:   n_state = S_FCHK;
            S_FCHK: begin
                if (seg_hit) n_state = S_FMUL;
                else if (r_idx + NW'(1) >= n_eff) n_state = S_FDONE;
                else n_state = S_FRD2;
            end
            S_FMUL:   n_state = (span == 10'd0) ? S_FDONE : S_DIV;
            S_FFIN:   n_state = S_FDONE;
            S_FDONE: begin
                if (!r_ch) n_state = S_FSTART;
                else n_state = (r_in.op == OP_CONTROL) ? S_OXY1 : S_SMA;
            end
            S_OXY1:   n_state = S_OXY2;
            S_OXY2:   n_state = S_SMA;
            S_SMA:    n_state = S_SMB;
            S_SMB:    n_state = k_last ? S_OUT : S_SMA;
            S_OUT:    if (i_out_ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // handshake and memory address
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        rd_addr     = r_idx[AW-1:0];
        unique case (r_state)
            S_IDLE:  o_in_ready = 1'b1;
            S_OUT:   o_out_valid = 1'b1;
            S_FRD:   rd_addr = '0;
            default: rd_addr = r_idx[AW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // table memory
    always_ff @(posedge i_clk) begin
        if (in_fire && (i_in.op == OP_POINT) && (32'(i_in.point_index) < MAX_POINTS)) begin
            mem[AW'(i_in.point_index)] <= '{i_in.point_insp_x, i_in.point_exp_x,
                                            i_in.point_flow_y};
        end
        r_rdata <= mem[rd_addr];
    end

    // configuration and smoothed state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_p  <= '0;
            r_zero_i  <= '0;
            r_zero_e  <= '0;
            r_gain    <= 16'd100;
            r_keep    <= 17'd58982;
            r_new     <= 17'd6554;
            r_pmax    <= 16'hFFFF;
            r_npoints <= 5'd2;
            r_sp      <= '0;
            r_si      <= '0;
            r_se      <= '0;
            r_so      <= '0;
            r_cp      <= '0;
            r_ci      <= '0;
            r_ce      <= '0;
            r_alarm   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_ZERO_P:  r_zero_p  <= i_cfg_data[9:0];
                    REG_ZERO_I:  r_zero_i  <= i_cfg_data[9:0];
                    REG_ZERO_E:  r_zero_e  <= i_cfg_data[9:0];
                    REG_GAIN:    r_gain    <= i_cfg_data[15:0];
                    REG_KEEP:    r_keep    <= i_cfg_data;
                    REG_NEW:     r_new     <= i_cfg_data;
                    REG_PMAX:    r_pmax    <= i_cfg_data[15:0];
                    REG_NPOINTS: r_npoints <= i_cfg_data[4:0];
                    default:     r_npoints <= r_npoints;
                endcase
            end
            if (r_state == S_OXY1) begin
                r_alarm <= r_inst >= r_pmax;
            end
            if (r_state == S_SMB) begin
                case (r_k)
                    SM_PRESS: r_sp <= (sm_res > 18'd65535) ? 16'hFFFF : sm_res[15:0];
                    SM_INSP:  r_si <= (sm_res > 18'd65535) ? 16'hFFFF : sm_res[15:0];
                    SM_EXP:   r_se <= (sm_res > 18'd65535) ? 16'hFFFF : sm_res[15:0];
                    SM_OXY:   r_so <= (sm_res > 18'd65535) ? 16'hFFFF : sm_res[15:0];
                    SM_CALP:  r_cp <= (sm_res > 18'd1023) ? 10'd1023 : sm_res[9:0];
                    SM_CALI:  r_ci <= (sm_res > 18'd1023) ? 10'd1023 : sm_res[9:0];
                    SM_CALE:  r_ce <= (sm_res > 18'd1023) ? 10'd1023 : sm_res[9:0];
                    default:  r_ce <= r_ce;
                endcase
            end
        end
    end

    // datapath working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_in <= i_in;
                r_ch <= 1'b0;
            end
            S_PMUL: begin
                r_inst <= '0;
                r_num  <= DIV_BITS'((r_in.raw_pressure - r_zero_p) * r_gain);
            end
            S_DIV: begin
                r_num <= {r_num[DIV_BITS-2:0], 1'b0};
                r_quo <= {r_quo[DIV_BITS-2:0], div_ge};
                r_rem <= div_ge ? 10'(rem_sh - {1'b0, r_den}) : rem_sh[9:0];
                r_cnt <= r_cnt + 5'd1;
            end
            S_PFIN: begin
                r_inst <= (p_scaled[52:33] > 20'hFFFF) ? 16'hFFFF : p_scaled[48:33];
            end
            S_FSTART: begin
                r_flow <= '0;
                r_p    <= raw_sel - zero_sel;
                r_idx  <= '0;
            end
            S_FLOAD: begin
                r_prev <= r_rdata;
                r_idx  <= NW'(1);
            end
            S_FCHK: begin
                if (seg_hit) begin
                    r_cur <= r_rdata;
                end else begin
                    r_prev <= r_rdata;
                    r_idx  <= r_idx + NW'(1);
                end
            end
            S_FMUL: begin
                r_flow <= r_prev.flow_y;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_den  <= span;
                // falling segment rounds the step up
                if (r_cur.flow_y >= r_prev.flow_y) begin
                    r_num <= DIV_BITS'(dx * (r_cur.flow_y - r_prev.flow_y));
                end else begin
                    r_num <= DIV_BITS'(dx * (r_prev.flow_y - r_cur.flow_y))
                           + DIV_BITS'(span - 10'd1);
                end
            end
            S_FFIN: begin
                if (r_cur.flow_y >= r_prev.flow_y) r_flow <= r_prev.flow_y + r_quo[15:0];
                else r_flow <= r_prev.flow_y - r_quo[15:0];
            end
            S_FDONE: begin
                if (r_ch) r_fe <= r_flow;
                else r_fi <= r_flow;
                r_ch <= 1'b1;
                r_k  <= SM_PRESS;
            end
            S_OXY1: begin
                r_tt  <= r_in.raw_oxygen * r_in.raw_oxygen;
                r_c1t <= 31'(O2_C1 * r_in.raw_oxygen);
            end
            S_OXY2: begin
                r_oxq <= oxy_v[32] ? 16'd0 : oxy_v[31:16];
            end
            S_SMA: begin
                r_acc <= sm_prev * r_keep;
            end
            S_SMB: begin
                r_k <= k_next;
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    assign o_out = '{r_inst, r_sp, r_si, r_se, r_so[15:8], r_alarm, r_cp, r_ci, r_ce};

endmodule
